@@ rtl/ssmi_pkg.sv @@
// Shared types, constants and tables of the stepper sine microstep indexer.
package ssmi_pkg;

   localparam int unsigned SINE_STEPS = 16;
   localparam int unsigned INDEX_W    = 4;
   localparam int unsigned PHASE_W    = 2;
   localparam int unsigned SINE_W     = 8;
   localparam int unsigned PWM_W      = 10;
   localparam int unsigned PATTERN_W  = 4;

   localparam logic [PWM_W-1:0] PWM_MAX_RESET = 10'd255;

   typedef enum logic {
      OP_MICRO = 1'b0,
      OP_FULL  = 1'b1
   } opcode_type;

   // Item held between the step stage and the duty stage.
   typedef struct packed {
      logic                 full;
      logic [INDEX_W-1:0]   index;
      logic                 swap;
      logic [PATTERN_W-1:0] pattern;
   } step_type;

   // Quarter sine, entries 0 to 16.
   function automatic logic [SINE_W-1:0] quarter_sine(input logic [INDEX_W:0] k);
      logic [SINE_W-1:0] v;
      begin
         unique case (k)
            5'd0:    v = 8'd0;
            5'd1:    v = 8'd25;
            5'd2:    v = 8'd50;
            5'd3:    v = 8'd74;
            5'd4:    v = 8'd98;
            5'd5:    v = 8'd120;
            5'd6:    v = 8'd141;
            5'd7:    v = 8'd162;
            5'd8:    v = 8'd180;
            5'd9:    v = 8'd197;
            5'd10:   v = 8'd212;
            5'd11:   v = 8'd225;
            5'd12:   v = 8'd236;
            5'd13:   v = 8'd244;
            5'd14:   v = 8'd250;
            5'd15:   v = 8'd253;
            default: v = 8'd255;
         endcase
         return v;
      end
   endfunction

   // Coil drive levels per phase, bit 0 first in the sequence.
   function automatic logic [PATTERN_W-1:0] phase_pattern(input logic [PHASE_W-1:0] p);
      logic [PATTERN_W-1:0] v;
      begin
         unique case (p)
            2'd0:    v = 4'hA;
            2'd1:    v = 4'h6;
            2'd2:    v = 4'h5;
            default: v = 4'h9;
         endcase
         return v;
      end
   endfunction

endpackage

@@ rtl/stepper_sine_microstep_indexer_core.sv @@
// Top level of the stepper sine microstep indexer.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------------
//   req_     | in        | req_tvalid/tready    | tuser: opcode; tdata: reverse
//   rsp_     | out       | rsp_tvalid/tready    | tdata: coil_pattern, duty_a, duty_b
//   csr_     | in        | csr_valid/csr_ready  | csr_wdata: pwm_max
//
// One item per cycle while rsp_tready holds; each item passes stage_ff and the result register:
// a step stage updates index and phase, a duty stage does the two table multiplies.
// Reset is synchronous: index, phase and stored duties clear, pwm_max returns to 255.
// A stalled result holds in the output register; the step stage fills behind it and
// req_tready drops only when both stages hold items.
module stepper_sine_microstep_indexer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] reverse
   input  logic                       req_tuser,   // [0] opcode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // [3:0] coil_pattern, [13:4] duty_a,
                                                   // [23:14] duty_b
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ssmi_pkg::PWM_W-1:0] csr_wdata
);
   import ssmi_pkg::*;

   logic [PWM_W-1:0]     pwm_max_ff;
   logic [INDEX_W-1:0]   index_ff,  index_in;
   logic [PHASE_W-1:0]   phase_ff,  phase_in;
   logic                 stage_valid_ff;
   step_type             stage_ff,  stage_in;
   logic                 rsp_valid_ff;
   logic [PATTERN_W-1:0] rsp_pattern_ff;
   logic [PWM_W-1:0]     rsp_duty_a_ff, rsp_duty_a_in;
   logic [PWM_W-1:0]     rsp_duty_b_ff, rsp_duty_b_in;
   logic [PWM_W-1:0]     last_duty_a_ff;
   logic [PWM_W-1:0]     last_duty_b_ff;
   logic [PWM_W-1:0]     calc_duty_a;
   logic [PWM_W-1:0]     calc_duty_b;
   logic                 req_accept;
   logic                 out_advance;
   logic                 reverse;
   opcode_type           opcode;

   assign opcode      = opcode_type'(req_tuser);
   assign reverse     = req_tdata[0];
   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !stage_valid_ff || out_advance;
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   // Step stage: move index and phase for the accepted item.
   always_comb begin
      index_in         = index_ff;
      phase_in         = phase_ff;
      stage_in.full    = 1'b0;
      stage_in.index   = index_ff;
      stage_in.swap    = phase_ff[0];
      stage_in.pattern = phase_pattern(phase_ff);
      unique case (opcode)
         OP_FULL: begin
            stage_in.full = 1'b1;
            phase_in      = reverse ? phase_ff - 1'b1 : phase_ff + 1'b1;
         end
         OP_MICRO: begin
            // Carry or borrow out of the index moves the phase.
            if (reverse) begin
               index_in = index_ff - 1'b1;
               phase_in = (index_ff == '0) ? phase_ff - 1'b1 : phase_ff;
            end else begin
               index_in = index_ff + 1'b1;
               phase_in = (index_ff == '1) ? phase_ff + 1'b1 : phase_ff;
            end
            stage_in.index   = index_in;
            stage_in.swap    = phase_in[0];
            stage_in.pattern = phase_pattern(phase_in);
         end
         default: ;
      endcase
   end

   ssmi_duty u_duty (
      .index   (stage_ff.index),
      .swap    (stage_ff.swap),
      .pwm_max (pwm_max_ff),
      .duty_a  (calc_duty_a),
      .duty_b  (calc_duty_b)
   );

   // Full steps repeat the stored duties.
   assign rsp_duty_a_in = stage_ff.full ? last_duty_a_ff : calc_duty_a;
   assign rsp_duty_b_in = stage_ff.full ? last_duty_b_ff : calc_duty_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_max_ff     <= PWM_MAX_RESET;
         index_ff       <= '0;
         phase_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_duty_a_ff <= '0;
         last_duty_b_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            pwm_max_ff <= csr_wdata;
         end
         if (req_accept) begin
            index_ff <= index_in;
            phase_ff <= phase_in;
         end
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (out_advance) begin
            rsp_valid_ff <= stage_valid_ff;
            if (stage_valid_ff && !stage_ff.full) begin
               last_duty_a_ff <= calc_duty_a;
               last_duty_b_ff <= calc_duty_b;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
      if (out_advance && stage_valid_ff) begin
         rsp_pattern_ff <= stage_ff.pattern;
         rsp_duty_a_ff  <= rsp_duty_a_in;
         rsp_duty_b_ff  <= rsp_duty_b_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_duty_b_ff, rsp_duty_a_ff, rsp_pattern_ff};

endmodule

@@ rtl/ssmi_duty.sv @@
// Winding duty calculation: scaled quarter-sine pair with winding swap.
module ssmi_duty (
   input  logic [ssmi_pkg::INDEX_W-1:0] index,
   input  logic                         swap,
   input  logic [ssmi_pkg::PWM_W-1:0]   pwm_max,
   output logic [ssmi_pkg::PWM_W-1:0]   duty_a,
   output logic [ssmi_pkg::PWM_W-1:0]   duty_b
);
   import ssmi_pkg::*;

   localparam int unsigned PROD_W = SINE_W + PWM_W;

   logic [INDEX_W:0]    mirror_idx;
   logic [PROD_W-1:0]   prod_hi;
   logic [PROD_W-1:0]   prod_lo;
   logic [PWM_W-1:0]    scaled_hi;
   logic [PWM_W-1:0]    scaled_lo;

   assign mirror_idx = (INDEX_W+1)'(SINE_STEPS) - {1'b0, index};
   assign prod_hi    = PROD_W'(quarter_sine({1'b0, index})) * PROD_W'(pwm_max);
   assign prod_lo    = PROD_W'(quarter_sine(mirror_idx)) * PROD_W'(pwm_max);
   assign scaled_hi  = prod_hi[PROD_W-1:SINE_W];
   assign scaled_lo  = prod_lo[PROD_W-1:SINE_W];

   // Odd phases drive the cosine side on winding A.
   assign duty_a = swap ? scaled_lo : scaled_hi;
   assign duty_b = swap ? scaled_hi : scaled_lo;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the stepper sine microstep indexer core.
`timescale 1ns / 1ps

module tb;
   import ssmi_pkg::*;

   // Result item as it sits in rsp_tdata, lowest field last.
   typedef struct packed {
      logic [PWM_W-1:0]     duty_b;
      logic [PWM_W-1:0]     duty_a;
      logic [PATTERN_W-1:0] pattern;
   } coil_drive_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [PWM_W-1:0]     csr_wdata;

   // Predictor state
   logic [INDEX_W-1:0]   step_index;
   logic [PHASE_W-1:0]   step_phase;
   logic [PWM_W-1:0]     kept_duty_a;
   logic [PWM_W-1:0]     kept_duty_b;
   logic [PWM_W-1:0]     pwm_full_scale;

   logic [SINE_W-1:0]    sine_lut [0:SINE_STEPS];
   logic [PATTERN_W-1:0] coil_seq [0:3];

   coil_drive_type       pending_drives [$];

   int unsigned          req_idle_pct;
   int unsigned          rsp_idle_pct;
   bit                   rsp_hold_req;
   int unsigned          rsp_hold_left;
   int unsigned          items_sent;
   int unsigned          drives_checked;
   int unsigned          mismatches;
   int unsigned          req_stall_cycles;
   int unsigned          pwm_writes;

   stepper_sine_microstep_indexer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [PWM_W-1:0] scaled_sine(input logic [INDEX_W:0] k);
      logic [17:0] prod;
      prod = sine_lut[k] * pwm_full_scale;
      return prod[17:8];
   endfunction

   // Advance the predictor by one step command and return the expected drive.
   function automatic coil_drive_type predict_coil_drive(input opcode_type op, input logic rev);
      coil_drive_type   d;
      logic [PWM_W-1:0] hi;
      logic [PWM_W-1:0] lo;
      if (op == OP_FULL) begin
         d.pattern  = coil_seq[step_phase];
         step_phase = rev ? step_phase - 2'd1 : step_phase + 2'd1;
      end else begin
         if (rev) begin
            if (step_index == 4'd0) step_phase = step_phase - 2'd1;
            step_index = step_index - 4'd1;
         end else begin
            if (step_index == 4'd15) step_phase = step_phase + 2'd1;
            step_index = step_index + 4'd1;
         end
         hi = scaled_sine({1'b0, step_index});
         lo = scaled_sine(5'd16 - {1'b0, step_index});
         // odd phases swap the windings
         if (step_phase[0]) begin
            kept_duty_a = lo;
            kept_duty_b = hi;
         end else begin
            kept_duty_a = hi;
            kept_duty_b = lo;
         end
         d.pattern = coil_seq[step_phase];
      end
      d.duty_a = kept_duty_a;
      d.duty_b = kept_duty_b;
      return d;
   endfunction

   task automatic send_step(input opcode_type op, input logic rev);
      coil_drive_type want;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, rev};
      @(posedge clock);
      while (!req_tready) begin
         req_stall_cycles++;
         @(posedge clock);
      end
      want = predict_coil_drive(op, rev);
      pending_drives.push_back(want);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pwm_max(input logic [PWM_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      pwm_full_scale  = value;
      pwm_writes++;
   endtask

   // Runs of steps in one direction, with stray direction flips as noise.
   task automatic run_walk(input int count);
      int         left;
      int         run_len;
      logic       rev;
      opcode_type op;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(40, 1);
         rev     = 1'($urandom_range(1));
         for (int k = 0; k < run_len && left > 0; k++) begin
            op = ($urandom_range(9) < 2) ? OP_FULL : OP_MICRO;
            if ($urandom_range(19) == 0) rev = ~rev;
            send_step(op, rev);
            left--;
         end
      end
   endtask

   // Full steps right after reset: stored duties are still zero, phase wraps both ways.
   task automatic test_reset_full_steps();
      send_step(OP_FULL, 1'b0);
      send_step(OP_FULL, 1'b0);
      send_step(OP_FULL, 1'b1);
      send_step(OP_FULL, 1'b1);
      send_step(OP_FULL, 1'b1);
      send_step(OP_FULL, 1'b0);
      wait_drained();
   endtask

   // Reverse wrap below index 0, forward wrap past 15, full step repeating duties.
   task automatic test_index_wrap();
      send_step(OP_MICRO, 1'b1);
      send_step(OP_MICRO, 1'b1);
      send_step(OP_MICRO, 1'b0);
      send_step(OP_MICRO, 1'b0);
      send_step(OP_MICRO, 1'b0);
      send_step(OP_FULL, 1'b0);
      wait_drained();
   endtask

   task automatic test_pwm_extremes();
      write_pwm_max('0);
      send_step(OP_MICRO, 1'b0);
      send_step(OP_MICRO, 1'b1);
      write_pwm_max(10'd1023);
      send_step(OP_MICRO, 1'b1);
      send_step(OP_MICRO, 1'b0);
      send_step(OP_FULL, 1'b1);
      send_step(OP_MICRO, 1'b0);
      write_pwm_max(PWM_MAX_RESET);
      wait_drained();
   endtask

   // Hold off the result side while items keep coming, then let everything drain.
   task automatic test_backpressure();
      int unsigned stalls_before;
      stalls_before = req_stall_cycles;
      req_idle_pct  = 0;
      rsp_hold_req  = 1'b1;
      while (rsp_hold_req) @(posedge clock);
      run_walk(60);
      wait_drained();
      if (req_stall_cycles == stalls_before)
         $display("%0t: note: input was never stalled during hold-off", $time);
      req_idle_pct = 34;
   endtask

   task automatic test_random_walk();
      logic [PWM_W-1:0] scales [0:5];
      scales[0] = 10'd1023;
      scales[1] = '0;
      scales[2] = 10'($urandom);
      scales[3] = 10'd1;
      scales[4] = 10'($urandom);
      scales[5] = 10'd512;
      for (int s = 0; s < 6; s++) begin
         write_pwm_max(scales[s]);
         // one segment runs flat out on both sides
         req_idle_pct = (s == 2) ? 0 : 34;
         rsp_idle_pct = (s == 2) ? 0 : 34;
         run_walk(215);
         wait_drained();
      end
      req_idle_pct = 34;
      rsp_idle_pct = 34;
   endtask

   // Result side: random ready, or a counted hold-off on request.
   always @(posedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_left = 250;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      coil_drive_type want;
      coil_drive_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_drives.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_drives.pop_front();
            drives_checked++;
            if (got.pattern !== want.pattern) begin
               $display("%0t: coil_pattern expected %h got %h",
                        $time, want.pattern, got.pattern);
               mismatches++;
            end
            if (got.duty_a !== want.duty_a) begin
               $display("%0t: duty_a expected %0d got %0d", $time, want.duty_a, got.duty_a);
               mismatches++;
            end
            if (got.duty_b !== want.duty_b) begin
               $display("%0t: duty_b expected %0d got %0d", $time, want.duty_b, got.duty_b);
               mismatches++;
            end
         end
      end
   end

   initial begin
      sine_lut = '{8'd0, 8'd25, 8'd50, 8'd74, 8'd98, 8'd120, 8'd141, 8'd162, 8'd180,
                   8'd197, 8'd212, 8'd225, 8'd236, 8'd244, 8'd250, 8'd253, 8'd255};
      coil_seq = '{4'hA, 4'h6, 4'h5, 4'h9};

      step_index       = '0;
      step_phase       = '0;
      kept_duty_a      = '0;
      kept_duty_b      = '0;
      pwm_full_scale   = PWM_MAX_RESET;
      req_idle_pct     = 34;
      rsp_idle_pct     = 34;
      rsp_hold_req     = 1'b0;
      rsp_hold_left    = 0;
      items_sent       = 0;
      drives_checked   = 0;
      mismatches       = 0;
      req_stall_cycles = 0;
      pwm_writes       = 0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_MICRO;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_full_steps();
      test_index_wrap();
      test_pwm_extremes();
      test_backpressure();
      test_random_walk();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Ran %0d step commands of both kinds and directions over %0d pwm_max settings,",
               items_sent, pwm_writes);
      $display("compared %0d results; input held off by back-pressure for %0d cycles.",
               drives_checked, req_stall_cycles);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/ssmi_pkg.sv
rtl/ssmi_duty.sv
rtl/stepper_sine_microstep_indexer_core.sv
tb/tb.sv
